// ===== rtl/virtio_common_config_regs_unit_macros.svh =====
// ----------------------------------------------------------------------------
// virtio common config macros
// assertion shorthands shared by the common-config register window
// ----------------------------------------------------------------------------
`ifndef VIRTIO_COMMON_CONFIG_REGS_UNIT_MACROS_SVH
`define VIRTIO_COMMON_CONFIG_REGS_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define VCCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define VCCR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vccr_pkg.sv =====
// ----------------------------------------------------------------------------
// vccr_pkg
// constants, offsets and helpers of the virtio common-config window
// ----------------------------------------------------------------------------
package vccr_pkg;

    // sizes
    localparam int MAX_QUEUES   = 8;
    localparam int QIDX_W       = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int WINDOW_BYTES = 64;
    localparam int BANKS        = 4;
    localparam int ROWS         = WINDOW_BYTES / BANKS;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int OFF_W        = 6;
    localparam int ADDR_W       = OFF_W + 1;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic CFG_FEATURE_BITS = 1'b0;
    localparam logic CFG_QUEUE_COUNT  = 1'b1;

    // access error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DF_WRITE = 2'd1;
    localparam logic [1:0] ERR_QSEL     = 2'd2;

    // decoded offsets
    localparam logic [OFF_W-1:0] OFF_DFSELECT = 6'd0;
    localparam logic [OFF_W-1:0] OFF_DF       = 6'd4;
    localparam logic [OFF_W-1:0] OFF_MSIX     = 6'd16;
    localparam logic [OFF_W-1:0] OFF_STATUS   = 6'd20;
    localparam logic [OFF_W-1:0] OFF_QSELECT  = 6'd22;
    localparam logic [OFF_W-1:0] OFF_QSIZE    = 6'd24;
    localparam logic [OFF_W-1:0] OFF_QMSIX    = 6'd26;
    localparam logic [OFF_W-1:0] OFF_QENABLE  = 6'd28;
    localparam logic [OFF_W-1:0] OFF_DESCLO   = 6'd32;
    localparam logic [OFF_W-1:0] OFF_DESCHI   = 6'd36;
    localparam logic [OFF_W-1:0] OFF_AVAILLO  = 6'd40;
    localparam logic [OFF_W-1:0] OFF_AVAILHI  = 6'd44;
    localparam logic [OFF_W-1:0] OFF_USEDLO   = 6'd48;
    localparam logic [OFF_W-1:0] OFF_USEDHI   = 6'd52;
    localparam logic [OFF_W-1:0] OFF_NOTIFY   = 6'd56;

    // preset bytes of the store
    localparam int MSIX_BYTE  = 16;
    localparam int COUNT_BYTE = 18;

    // register values
    localparam logic [15:0] NO_VECTOR          = 16'hffff;
    localparam int          STATUS_FAILED_BIT  = 7;
    localparam logic [63:0] FEATURE_BITS_RESET = 64'h0000_0001_0000_0000;
    localparam logic [3:0]  QUEUE_COUNT_RESET  = 4'd8;

    // position within the access of the byte that lands in a bank
    function automatic logic [1:0] lane_index(input logic [OFF_W-1:0] off,
                                              input logic [1:0] bank);
        return bank - off[1:0];
    endfunction

    // window byte address that a bank serves for an access
    function automatic logic [ADDR_W-1:0] lane_addr(input logic [OFF_W-1:0] off,
                                                    input logic [1:0] bank);
        return {1'b0, off} + ADDR_W'(lane_index(off, bank));
    endfunction

    // store content of a byte never written since reset
    function automatic logic [7:0] store_reset_byte(input logic [ADDR_W-1:0] addr);
        logic [7:0] b;
        b = 8'h00;
        if (addr == ADDR_W'(MSIX_BYTE) || addr == ADDR_W'(MSIX_BYTE + 1))
            b = 8'hff;
        else if (addr == ADDR_W'(COUNT_BYTE))
            b = {4'h0, QUEUE_COUNT_RESET};
        return b;
    endfunction

    // offsets that act on the selected queue
    function automatic logic is_queue_offset(input logic [OFF_W-1:0] off);
        return off == OFF_QSIZE || off == OFF_QMSIX || off == OFF_QENABLE ||
               (off >= OFF_DESCLO && off <= OFF_NOTIFY && off[1:0] == 2'b00);
    endfunction

endpackage

// ===== rtl/virtio_common_config_regs_unit.sv =====
// ----------------------------------------------------------------------------
// virtio_common_config_regs_unit
// common-config register window: decoded registers plus a byte store
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        slave      in_valid / in_stall       opcode offset access_bytes write_data
//  out       master     out_valid / out_stall     read_data notify_fire notify_value
//                                                 driver_failed access_error
//  cfg       slave      cfg_we                    cfg_index cfg_data
//
//  one transaction per cycle sustained while out_stall allows; out_valid marks the
//  result register; decode, register update and the byte store write all happen
//  as the transaction leaves the input register into the result register
//  the byte store is four byte-wide banks with a registered read port,
//  read on accept and patched by one-deep forwarding of the previous write
//  reset clears store valid bits at once; out_stall reaches in_stall directly
// ----------------------------------------------------------------------------
`include "virtio_common_config_regs_unit_macros.svh"

module virtio_common_config_regs_unit
    import vccr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [OFF_W-1:0]  offset,
    input  logic [2:0]        access_bytes,
    input  logic [31:0]       write_data,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       read_data,
    output logic              notify_fire,
    output logic [15:0]       notify_value,
    output logic              driver_failed,
    output logic [1:0]        access_error,
    // configuration port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);

    // pipeline control
    logic              s1_valid_reg;
    logic              s1_opcode_reg;
    logic [OFF_W-1:0]  s1_offset_reg;
    logic [2:0]        s1_bytes_reg;
    logic [31:0]       s1_data_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              accept;

    // configuration registers
    logic [63:0]       feature_bits_reg;
    logic [3:0]        queue_count_reg;

    // decoded registers
    logic [31:0]       feature_select_reg;
    logic [15:0]       config_vector_reg;
    logic [15:0]       queue_select_reg;
    logic [15:0]       queue_size_reg   [MAX_QUEUES];
    logic [15:0]       queue_vector_reg [MAX_QUEUES];
    logic [15:0]       queue_enable_reg [MAX_QUEUES];
    logic [63:0]       ring_desc_reg    [MAX_QUEUES];
    logic [63:0]       ring_avail_reg   [MAX_QUEUES];
    logic [63:0]       ring_used_reg    [MAX_QUEUES];

    // byte store banks
    logic [7:0]        bank_mem     [BANKS][ROWS];
    logic [ROWS-1:0]   store_valid_reg [BANKS];
    logic [7:0]        rd_data_reg  [BANKS];
    logic              rd_valid_reg [BANKS];
    logic              fwd_reg      [BANKS];
    logic [7:0]        fwd_data_reg [BANKS];
    logic [ADDR_W-1:0] in_adr       [BANKS];
    logic [ROW_W-1:0]  in_row       [BANKS];
    logic [1:0]        lane_idx     [BANKS];
    logic [ADDR_W-1:0] lane_adr     [BANKS];
    logic [ROW_W-1:0]  lane_row     [BANKS];
    logic              lane_use     [BANKS];
    logic [7:0]        lane_wbyte   [BANKS];
    logic [7:0]        lane_byte    [BANKS];
    logic              mem_we       [BANKS];
    logic [ROW_W-1:0]  mem_wrow     [BANKS];
    logic [7:0]        mem_wdata    [BANKS];

    // decode stage signals
    logic [2:0]        len;
    logic [31:0]       data_m;
    logic              is_write;
    logic [15:0]       q_limit;
    logic              qok;
    logic [QIDX_W-1:0] q;
    logic [31:0]       store_word;
    logic [31:0]       rd;
    logic              fire;
    logic [15:0]       nval;
    logic              failed;
    logic [1:0]        err;

    // result registers
    logic [31:0]       read_data_reg;
    logic              notify_fire_reg;
    logic [15:0]       notify_value_reg;
    logic              driver_failed_reg;
    logic [1:0]        access_error_reg;

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= opcode;
            s1_offset_reg <= offset;
            s1_bytes_reg  <= access_bytes;
            s1_data_reg   <= write_data;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_bits_reg <= FEATURE_BITS_RESET;
            queue_count_reg  <= QUEUE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FEATURE_BITS: feature_bits_reg <= cfg_data;
                CFG_QUEUE_COUNT:  queue_count_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // length clamp and write data mask
    always_comb
    begin
        len = s1_bytes_reg;
        if (s1_bytes_reg == 3'd0)
            len = 3'd1;
        else if (s1_bytes_reg > 3'd4)
            len = 3'd4;
        case (len)
            3'd1:    data_m = {24'h0, s1_data_reg[7:0]};
            3'd2:    data_m = {16'h0, s1_data_reg[15:0]};
            3'd3:    data_m = {8'h0, s1_data_reg[23:0]};
            default: data_m = s1_data_reg;
        endcase
    end

    assign is_write = (s1_opcode_reg == OP_WRITE);

    // queue select range check
    assign q_limit = ({12'h0, queue_count_reg} > 16'(MAX_QUEUES)) ? 16'(MAX_QUEUES)
                   : {12'h0, queue_count_reg};
    assign qok     = queue_select_reg < q_limit;
    assign q       = qok ? queue_select_reg[QIDX_W-1:0] : '0;

    // per-bank lane geometry
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            in_adr[b]     = lane_addr(offset, 2'(b));
            in_row[b]     = in_adr[b][ROW_W+1:2];
            lane_idx[b]   = lane_index(s1_offset_reg, 2'(b));
            lane_adr[b]   = lane_addr(s1_offset_reg, 2'(b));
            lane_row[b]   = lane_adr[b][ROW_W+1:2];
            lane_use[b]   = ({1'b0, lane_idx[b]} < len) &&
                            (lane_adr[b] < ADDR_W'(WINDOW_BYTES));
            lane_wbyte[b] = data_m[8*lane_idx[b] +: 8];
            lane_byte[b]  = fwd_reg[b] ? fwd_data_reg[b]
                          : rd_valid_reg[b] ? rd_data_reg[b]
                          : store_reset_byte(lane_adr[b]);
        end
    end

    // bank write port: transaction bytes, else the queue count preset
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            mem_we[b]    = 1'b0;
            mem_wrow[b]  = lane_row[b];
            mem_wdata[b] = lane_wbyte[b];
            if (advance && is_write && lane_use[b])
            begin
                mem_we[b] = 1'b1;
            end
            else if (cfg_we && cfg_index == CFG_QUEUE_COUNT)
            begin
                if (2'(b) == 2'(COUNT_BYTE % BANKS))
                begin
                    mem_we[b]    = 1'b1;
                    mem_wrow[b]  = ROW_W'(COUNT_BYTE / BANKS);
                    mem_wdata[b] = {4'h0, cfg_data[3:0]};
                end
                else if (2'(b) == 2'((COUNT_BYTE + 1) % BANKS))
                begin
                    mem_we[b]    = 1'b1;
                    mem_wrow[b]  = ROW_W'((COUNT_BYTE + 1) / BANKS);
                    mem_wdata[b] = 8'h00;
                end
            end
        end
    end

    // bank storage with registered read on accept
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (mem_we[b])
                bank_mem[b][mem_wrow[b]] <= mem_wdata[b];
            if (accept)
            begin
                rd_data_reg[b]  <= bank_mem[b][in_row[b]];
                rd_valid_reg[b] <= store_valid_reg[b][in_row[b]];
                fwd_reg[b]      <= advance && is_write && lane_use[b] &&
                                   (lane_row[b] == in_row[b]);
                fwd_data_reg[b] <= lane_wbyte[b];
            end
        end
    end

    // store valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BANKS; b++)
                store_valid_reg[b] <= '0;
        end
        else
        begin
            for (int b = 0; b < BANKS; b++)
                if (mem_we[b])
                    store_valid_reg[b][mem_wrow[b]] <= 1'b1;
        end
    end

    // store word in access byte order
    always_comb
    begin
        logic [1:0] k;
        for (int i = 0; i < 4; i++)
        begin
            k = s1_offset_reg[1:0] + 2'(i);
            store_word[8*i +: 8] = lane_use[k] ? lane_byte[k] : 8'h00;
        end
    end

    // decoded register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_select_reg <= '0;
            config_vector_reg  <= NO_VECTOR;
            queue_select_reg   <= '0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                queue_size_reg[i]   <= '0;
                queue_vector_reg[i] <= NO_VECTOR;
                queue_enable_reg[i] <= '0;
                ring_desc_reg[i]    <= '0;
                ring_avail_reg[i]   <= '0;
                ring_used_reg[i]    <= '0;
            end
        end
        else if (advance && is_write)
        begin
            case (s1_offset_reg)
                OFF_DFSELECT: feature_select_reg <= data_m;
                OFF_MSIX:     config_vector_reg  <= data_m[15:0];
                OFF_STATUS:
                begin
                    // status of zero resets queue state and the config vector, sizes stay
                    if (data_m == 32'h0)
                    begin
                        queue_select_reg  <= '0;
                        config_vector_reg <= NO_VECTOR;
                        for (int i = 0; i < MAX_QUEUES; i++)
                        begin
                            queue_vector_reg[i] <= NO_VECTOR;
                            queue_enable_reg[i] <= '0;
                            ring_desc_reg[i]    <= '0;
                            ring_avail_reg[i]   <= '0;
                            ring_used_reg[i]    <= '0;
                        end
                    end
                end
                OFF_QSELECT:  queue_select_reg <= data_m[15:0];
                OFF_QSIZE:    if (qok) queue_size_reg[q]   <= data_m[15:0];
                OFF_QMSIX:    if (qok) queue_vector_reg[q] <= data_m[15:0];
                OFF_QENABLE:  if (qok) queue_enable_reg[q] <= data_m[15:0];
                OFF_DESCLO:   if (qok) ring_desc_reg[q][31:0]   <= data_m;
                OFF_DESCHI:   if (qok) ring_desc_reg[q][63:32]  <= data_m;
                OFF_AVAILLO:  if (qok) ring_avail_reg[q][31:0]  <= data_m;
                OFF_AVAILHI:  if (qok) ring_avail_reg[q][63:32] <= data_m;
                OFF_USEDLO:   if (qok) ring_used_reg[q][31:0]   <= data_m;
                OFF_USEDHI:   if (qok) ring_used_reg[q][63:32]  <= data_m;
                default: ;
            endcase
        end
    end

    // result of the transaction in the input register
    always_comb
    begin
        rd     = 32'h0;
        fire   = 1'b0;
        nval   = 16'h0;
        failed = 1'b0;
        err    = (is_queue_offset(s1_offset_reg) && !qok) ? ERR_QSEL : ERR_NONE;
        if (is_write)
        begin
            case (s1_offset_reg)
                OFF_DF:     err    = ERR_DF_WRITE;
                OFF_STATUS: failed = data_m[STATUS_FAILED_BIT];
                OFF_NOTIFY:
                begin
                    if (qok && queue_enable_reg[q] != 16'h0)
                    begin
                        fire = 1'b1;
                        nval = data_m[15:0];
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            case (s1_offset_reg)
                OFF_DFSELECT: rd = feature_select_reg;
                OFF_DF:
                begin
                    if (feature_select_reg == 32'd0)
                        rd = feature_bits_reg[31:0];
                    else if (feature_select_reg == 32'd1)
                        rd = feature_bits_reg[63:32];
                end
                OFF_MSIX:     rd = {16'h0, config_vector_reg};
                OFF_QSELECT:  rd = {16'h0, queue_select_reg};
                OFF_QSIZE:    rd = qok ? {16'h0, queue_size_reg[q]}   : 32'h0;
                OFF_QMSIX:    rd = qok ? {16'h0, queue_vector_reg[q]} : 32'h0;
                OFF_QENABLE:  rd = qok ? {16'h0, queue_enable_reg[q]} : 32'h0;
                OFF_DESCLO:   rd = qok ? ring_desc_reg[q][31:0]   : 32'h0;
                OFF_DESCHI:   rd = qok ? ring_desc_reg[q][63:32]  : 32'h0;
                OFF_AVAILLO:  rd = qok ? ring_avail_reg[q][31:0]  : 32'h0;
                OFF_AVAILHI:  rd = qok ? ring_avail_reg[q][63:32] : 32'h0;
                OFF_USEDLO:   rd = qok ? ring_used_reg[q][31:0]   : 32'h0;
                OFF_USEDHI:   rd = qok ? ring_used_reg[q][63:32]  : 32'h0;
                OFF_NOTIFY:   rd = qok ? store_word : 32'h0;
                default:      rd = store_word;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg     <= rd;
            notify_fire_reg   <= fire;
            notify_value_reg  <= nval;
            driver_failed_reg <= failed;
            access_error_reg  <= err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign notify_fire   = notify_fire_reg;
    assign notify_value  = notify_value_reg;
    assign driver_failed = driver_failed_reg;
    assign access_error  = access_error_reg;

    // checks
    `VCCR_ASSERT(a_fire_no_error, out_valid && notify_fire |-> access_error == ERR_NONE, "notify with access error")
    `VCCR_ASSERT(a_value_needs_fire, out_valid && !notify_fire |-> notify_value == 16'h0, "notify value without notify")
    `VCCR_ASSERT(a_failed_not_notify, out_valid && driver_failed |-> !notify_fire, "failed status and notify together")
    `VCCR_ASSERT(a_held_stage_stable, s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_offset_reg), "held transaction lost")
    `VCCR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid && !in_stall, "pipeline not empty in reset")

endmodule
